// ===== hw/rtl/ctok_pkg.sv =====
// Shared types, token codes and character helpers for the C subset tokenizer.
// Used by every RTL module of the block and by its checker; no dependencies.
package ctok_pkg;

    localparam int CTOK_POSITION_BITS = 16;
    localparam int CTOK_KEYWORD_CHARS = 6;

    localparam logic [5:0] K_END      = 6'd0;
    localparam logic [5:0] K_IDENT    = 6'd1;
    localparam logic [5:0] K_KEYWORD  = 6'd2;
    localparam logic [5:0] K_TYPE     = 6'd3;
    localparam logic [5:0] K_RETURN   = 6'd4;
    localparam logic [5:0] K_INT      = 6'd5;
    localparam logic [5:0] K_FLOAT    = 6'd6;
    localparam logic [5:0] K_STRING   = 6'd7;
    localparam logic [5:0] K_CHAR     = 6'd8;
    localparam logic [5:0] K_PRE      = 6'd9;
    localparam logic [5:0] K_ERROR    = 6'd10;
    localparam logic [5:0] K_LPAREN   = 6'd11;
    localparam logic [5:0] K_RPAREN   = 6'd12;
    localparam logic [5:0] K_LBRACE   = 6'd13;
    localparam logic [5:0] K_RBRACE   = 6'd14;
    localparam logic [5:0] K_LBRACKET = 6'd15;
    localparam logic [5:0] K_RBRACKET = 6'd16;
    localparam logic [5:0] K_SEMI     = 6'd17;
    localparam logic [5:0] K_COMMA    = 6'd18;
    localparam logic [5:0] K_INC      = 6'd19;
    localparam logic [5:0] K_PLUS     = 6'd20;
    localparam logic [5:0] K_DEC      = 6'd21;
    localparam logic [5:0] K_MINUS    = 6'd22;
    localparam logic [5:0] K_NE       = 6'd23;
    localparam logic [5:0] K_NOT      = 6'd24;
    localparam logic [5:0] K_LAND     = 6'd25;
    localparam logic [5:0] K_AMP      = 6'd26;
    localparam logic [5:0] K_STAR     = 6'd27;
    localparam logic [5:0] K_SLASH    = 6'd28;
    localparam logic [5:0] K_PERCENT  = 6'd29;
    localparam logic [5:0] K_EQ       = 6'd30;
    localparam logic [5:0] K_ASSIGN   = 6'd31;
    localparam logic [5:0] K_GE       = 6'd32;
    localparam logic [5:0] K_GT       = 6'd33;
    localparam logic [5:0] K_LE       = 6'd34;
    localparam logic [5:0] K_LT       = 6'd35;
    localparam logic [5:0] K_LOR      = 6'd36;
    localparam logic [5:0] K_SYMBOL   = 6'd37;

    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_UNDER  = 8'h5F;

    localparam int KW_COUNT = 9;
    localparam logic [47:0] KW_TEXT [KW_COUNT] = '{
        48'h6E7275746572, 48'h6669, 48'h65736C65, 48'h726F66, 48'h656C696877,
        48'h72616863, 48'h74616F6C66, 48'h746E69, 48'h64696F76
    };
    localparam logic [2:0] KW_LEN [KW_COUNT] = '{
        3'd6, 3'd2, 3'd4, 3'd3, 3'd5, 3'd4, 3'd5, 3'd3, 3'd4
    };
    localparam logic [5:0] KW_KIND [KW_COUNT] = '{
        K_RETURN, K_KEYWORD, K_KEYWORD, K_KEYWORD, K_KEYWORD,
        K_TYPE, K_TYPE, K_TYPE, K_TYPE
    };

    typedef enum logic [2:0] {
        M_IDLE, M_WORD, M_NUM, M_STR, M_CHR_OPEN, M_CHR_BODY, M_PRE, M_OPER
    } t_mode;

    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_input;
    } t_in_item;

    typedef struct packed {
        logic [5:0]  token_kind;
        logic [15:0] start_line;
        logic [15:0] start_column;
        logic [15:0] token_length;
        logic        last_of_run;
    } t_out_item;

    typedef struct packed {
        logic      any;
        logic      has_second;
        t_out_item res0;
        t_out_item res1;
    } t_tok_pair;

    typedef struct packed {
        logic       pairable;
        logic [7:0] second;
        logic [5:0] pair_kind;
        logic [5:0] lone_kind;
    } t_pair_info;

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic logic [5:0] single_code(input logic [7:0] c);
        logic [5:0] k;
        unique case (c)
            8'h28:   k = K_LPAREN;
            8'h29:   k = K_RPAREN;
            8'h7B:   k = K_LBRACE;
            8'h7D:   k = K_RBRACE;
            8'h5B:   k = K_LBRACKET;
            8'h5D:   k = K_RBRACKET;
            8'h3B:   k = K_SEMI;
            8'h2C:   k = K_COMMA;
            8'h2A:   k = K_STAR;
            8'h2F:   k = K_SLASH;
            8'h25:   k = K_PERCENT;
            default: k = K_SYMBOL;
        endcase
        return k;
    endfunction

    function automatic t_pair_info pair_info(input logic [7:0] c);
        t_pair_info p;
        p = '0;
        p.pairable = 1'b1;
        unique case (c)
            8'h2B: begin p.second = 8'h2B; p.pair_kind = K_INC;  p.lone_kind = K_PLUS;   end
            8'h2D: begin p.second = 8'h2D; p.pair_kind = K_DEC;  p.lone_kind = K_MINUS;  end
            8'h21: begin p.second = 8'h3D; p.pair_kind = K_NE;   p.lone_kind = K_NOT;    end
            8'h26: begin p.second = 8'h26; p.pair_kind = K_LAND; p.lone_kind = K_AMP;    end
            8'h3D: begin p.second = 8'h3D; p.pair_kind = K_EQ;   p.lone_kind = K_ASSIGN; end
            8'h3E: begin p.second = 8'h3D; p.pair_kind = K_GE;   p.lone_kind = K_GT;     end
            8'h3C: begin p.second = 8'h3D; p.pair_kind = K_LE;   p.lone_kind = K_LT;     end
            8'h7C: begin p.second = 8'h7C; p.pair_kind = K_LOR;  p.lone_kind = K_SYMBOL; end
            default: begin
                p.pairable  = 1'b0;
                p.lone_kind = K_SYMBOL;
            end
        endcase
        return p;
    endfunction

endpackage

// ===== hw/rtl/ctok_lexer.sv =====
// Lexer state registers and the per-byte next-state and token logic.
// Depends on ctok_pkg; produces up to two token records per request.
module ctok_lexer import ctok_pkg::*; #(
    parameter int POSITION_BITS = CTOK_POSITION_BITS,
    parameter int KEYWORD_CHARS = CTOK_KEYWORD_CHARS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_adv,
    input  t_in_item  i_req,
    output t_tok_pair o_pair
);

    localparam int PB = POSITION_BITS;
    localparam int WB = 8 * KEYWORD_CHARS;
    localparam int EW = (PB > 16) ? PB : 17;
    localparam logic [PB-1:0] POS_MAX = '1;

    t_mode          r_mode, n_mode;
    logic [PB-1:0]  r_line, n_line, r_col, n_col;
    logic [PB-1:0]  r_tsl, n_tsl, r_tsc, n_tsc, r_len, n_len;
    logic           r_dot, n_dot;
    logic [7:0]     r_pend, n_pend;
    logic [WB-1:0]  r_prefix, n_prefix;

    logic [7:0]     c;
    logic [PB-1:0]  len_inc;
    logic [5:0]     word_kind;
    t_pair_info     pend_info, c_info;
    logic           restart;
    logic           a_vld, b_vld;
    logic [5:0]     a_kind, b_kind;
    logic [PB-1:0]  a_len, b_len;
    t_out_item      res_a, res_b;

    function automatic logic [15:0] clamp16(input logic [PB-1:0] v);
        logic [EW-1:0] e;
        e = EW'(v);
        return (e > EW'(16'hFFFF)) ? 16'hFFFF : e[15:0];
    endfunction

    always_comb begin
        word_kind = K_IDENT;
        for (int i = KW_COUNT - 1; i >= 0; i--) begin
            if (r_len == PB'(KW_LEN[i]) && r_prefix == WB'(KW_TEXT[i])) begin
                word_kind = KW_KIND[i];
            end
        end
    end

    assign c         = i_req.char_code;
    assign len_inc   = (r_len != POS_MAX) ? r_len + 1'b1 : r_len;
    assign pend_info = pair_info(r_pend);
    assign c_info    = pair_info(c);

    always_comb begin
        n_mode   = r_mode;
        n_line   = r_line;
        n_col    = r_col;
        n_tsl    = r_tsl;
        n_tsc    = r_tsc;
        n_len    = r_len;
        n_dot    = r_dot;
        n_pend   = r_pend;
        n_prefix = r_prefix;
        restart  = 1'b0;
        a_vld    = 1'b0;
        a_kind   = K_ERROR;
        a_len    = r_len;
        b_vld    = 1'b0;
        b_kind   = K_END;
        b_len    = '0;
        if (i_req.end_of_input) begin
            unique case (r_mode)
                M_IDLE:     a_vld = 1'b0;
                M_WORD:     begin a_vld = 1'b1; a_kind = word_kind; end
                M_NUM:      begin a_vld = 1'b1; a_kind = r_dot ? K_FLOAT : K_INT; end
                M_STR, M_CHR_OPEN, M_CHR_BODY: begin a_vld = 1'b1; a_kind = K_ERROR; end
                M_PRE:      begin a_vld = 1'b1; a_kind = K_PRE; end
                M_OPER:     begin a_vld = 1'b1; a_kind = pend_info.lone_kind; end
            endcase
            b_vld    = 1'b1;
            n_mode   = M_IDLE;
            n_len    = '0;
            n_dot    = 1'b0;
            n_pend   = '0;
            n_prefix = '0;
        end else begin
            unique case (r_mode)
                M_IDLE: restart = 1'b1;
                M_WORD: begin
                    if (is_alpha(c) || is_digit(c) || c == CH_UNDER) begin
                        for (int j = 0; j < KEYWORD_CHARS; j++) begin
                            if (r_len == PB'(j)) begin
                                n_prefix[8*j +: 8] = c;
                            end
                        end
                        n_len = len_inc;
                    end else begin
                        a_vld   = 1'b1;
                        a_kind  = word_kind;
                        restart = 1'b1;
                    end
                end
                M_NUM: begin
                    if (is_digit(c)) begin
                        n_len = len_inc;
                    end else if (c == CH_DOT && !r_dot) begin
                        n_dot = 1'b1;
                        n_len = len_inc;
                    end else begin
                        a_vld   = 1'b1;
                        a_kind  = (c == CH_DOT) ? K_ERROR : (r_dot ? K_FLOAT : K_INT);
                        restart = 1'b1;
                    end
                end
                M_STR: begin
                    n_len = len_inc;
                    if (c == CH_DQUOTE) begin
                        a_vld  = 1'b1;
                        a_kind = K_STRING;
                        a_len  = len_inc;
                        n_mode = M_IDLE;
                    end
                end
                M_CHR_OPEN: begin
                    n_len = len_inc;
                    if (c == CH_SQUOTE) begin
                        a_vld  = 1'b1;
                        a_kind = K_CHAR;
                        a_len  = len_inc;
                        n_mode = M_IDLE;
                    end else begin
                        n_mode = M_CHR_BODY;
                    end
                end
                M_CHR_BODY: begin
                    a_vld = 1'b1;
                    if (c == CH_SQUOTE) begin
                        n_len  = len_inc;
                        a_kind = K_CHAR;
                        a_len  = len_inc;
                        n_mode = M_IDLE;
                    end else begin
                        a_kind  = K_ERROR;
                        restart = 1'b1;
                    end
                end
                M_PRE: begin
                    if (c == CH_NL) begin
                        a_vld   = 1'b1;
                        a_kind  = K_PRE;
                        restart = 1'b1;
                    end else begin
                        n_len = len_inc;
                    end
                end
                M_OPER: begin
                    a_vld = 1'b1;
                    if (pend_info.pairable && c == pend_info.second) begin
                        n_len  = len_inc;
                        a_kind = pend_info.pair_kind;
                        a_len  = len_inc;
                        n_mode = M_IDLE;
                    end else begin
                        a_kind  = pend_info.lone_kind;
                        restart = 1'b1;
                    end
                    n_pend = '0;
                end
            endcase

            if (restart) begin
                n_tsl    = r_line;
                n_tsc    = r_col;
                n_len    = PB'(1);
                n_dot    = 1'b0;
                n_prefix = '0;
                priority if (is_space(c)) begin
                    n_mode = M_IDLE;
                    n_len  = '0;
                end else if (is_alpha(c) || c == CH_UNDER) begin
                    n_mode       = M_WORD;
                    n_prefix[7:0] = c;
                end else if (is_digit(c)) begin
                    n_mode = M_NUM;
                end else if (c == CH_DQUOTE) begin
                    n_mode = M_STR;
                end else if (c == CH_SQUOTE) begin
                    n_mode = M_CHR_OPEN;
                end else if (c == CH_HASH) begin
                    n_mode = M_PRE;
                end else if (c_info.pairable) begin
                    n_mode = M_OPER;
                    n_pend = c;
                end else begin
                    n_mode = M_IDLE;
                    b_vld  = 1'b1;
                    b_kind = single_code(c);
                    b_len  = PB'(1);
                end
            end

            if (c == CH_NL) begin
                n_line = (r_line != POS_MAX) ? r_line + 1'b1 : r_line;
                n_col  = PB'(1);
            end else begin
                n_col = (r_col != POS_MAX) ? r_col + 1'b1 : r_col;
            end
        end
    end

    always_comb begin
        res_a.token_kind   = a_kind;
        res_a.start_line   = clamp16(r_tsl);
        res_a.start_column = clamp16(r_tsc);
        res_a.token_length = clamp16(a_len);
        res_a.last_of_run  = !b_vld;
        res_b.token_kind   = b_kind;
        res_b.start_line   = clamp16(r_line);
        res_b.start_column = clamp16(r_col);
        res_b.token_length = clamp16(b_len);
        res_b.last_of_run  = 1'b1;
        o_pair.any         = a_vld || b_vld;
        o_pair.has_second  = a_vld && b_vld;
        o_pair.res0        = a_vld ? res_a : res_b;
        o_pair.res1        = res_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= M_IDLE;
            r_line   <= PB'(1);
            r_col    <= PB'(1);
            r_tsl    <= '0;
            r_tsc    <= '0;
            r_len    <= '0;
            r_dot    <= 1'b0;
            r_pend   <= '0;
            r_prefix <= '0;
        end else if (i_adv) begin
            r_mode   <= n_mode;
            r_line   <= n_line;
            r_col    <= n_col;
            r_tsl    <= n_tsl;
            r_tsc    <= n_tsc;
            r_len    <= n_len;
            r_dot    <= n_dot;
            r_pend   <= n_pend;
            r_prefix <= n_prefix;
        end
    end

endmodule

// ===== hw/rtl/ctok_out_queue.sv =====
// Two-slot queue of token-record pairs feeding the output channel one record at a time.
// Depends on ctok_pkg for the pair and record types.
module ctok_out_queue import ctok_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_tok_pair i_pair,
    output logic      o_space,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_item o_req
);

    t_tok_pair  r_mem [2];
    logic       r_wr_ptr, r_rd_ptr, r_sub;
    logic [1:0] r_count;
    t_tok_pair  head;
    logic       pop, head_done;

    assign head      = r_mem[r_rd_ptr];
    assign o_valid   = r_count != 2'd0;
    assign o_space   = r_count != 2'd2;
    assign o_req     = r_sub ? head.res1 : head.res0;
    assign pop       = o_valid && i_ready;
    assign head_done = pop && (r_sub || !head.has_second);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_pair;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_sub    <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (head_done) begin
                r_rd_ptr <= !r_rd_ptr;
                r_sub    <= 1'b0;
            end else if (pop) begin
                r_sub <= 1'b1;
            end
            r_count <= r_count + 2'(i_push) - 2'(head_done);
        end
    end

endmodule

// ===== hw/rtl/c_subset_tokenizer.sv =====
// A result passes through the input register and a queue slot before it is offered at the output.
// Throughput: one request per cycle while the queue has room; paired tokens leave one at a time.
// Input register, lexer and a two-pair output queue decouple the channels.
// Reset: synchronous active-low; line and column return to 1, scanner goes idle, queue empties.
// Top level of the C subset tokenizer; depends on ctok_pkg, ctok_lexer and ctok_out_queue.
module c_subset_tokenizer import ctok_pkg::*; #(
    parameter int POSITION_BITS = CTOK_POSITION_BITS,
    parameter int KEYWORD_CHARS = CTOK_KEYWORD_CHARS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_req,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_req
);

    logic      r_in_vld;
    t_in_item  r_in;
    logic      q_space, adv;
    t_tok_pair pair;

    assign adv        = r_in_vld && q_space;
    assign o_in_ready = !r_in_vld || q_space;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_req;
        end
    end

    ctok_lexer #(
        .POSITION_BITS (POSITION_BITS),
        .KEYWORD_CHARS (KEYWORD_CHARS)
    ) u_lexer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_req   (r_in),
        .o_pair  (pair)
    );

    ctok_out_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (adv && pair.any),
        .i_pair  (pair),
        .o_space (q_space),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_req   (o_out_req)
    );

endmodule

// ===== hw/rtl/ctok_checker.sv =====
// Port-level checks for the C subset tokenizer, bound to the top level.
// Depends on ctok_pkg for the record type and token codes.
module ctok_checker import ctok_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input t_in_item  i_in_req,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_item o_out_req
);

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_ready |=> i_in_valid && $stable(i_in_req))
        else $error("input request dropped or changed while waiting");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_req))
        else $error("output request changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

    a_end_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_req.token_kind == K_END |->
            o_out_req.last_of_run && o_out_req.token_length == 16'd0)
        else $error("end token not last or not empty");

    a_line_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_req.start_line != 16'd0)
        else $error("token start line is zero");

endmodule

bind c_subset_tokenizer ctok_checker u_ctok_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_req    (i_in_req),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_req   (o_out_req)
);

// ===== dv/c_subset_tokenizer_tb.sv =====
// Self-checking testbench for c_subset_tokenizer: streams source bytes and checks every token.
// Holds a token scoreboard class that predicts tokens from the accepted bytes; needs ctok_pkg.
// Covers idle and stall mixes, a drain pause, and end-of-input flushes of open tokens.
module c_subset_tokenizer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ctok_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int PHASE_ITEMS    = 410;

    class token_scoreboard;
        t_mode       mode;
        logic [15:0] line_no;
        logic [15:0] col_no;
        logic [15:0] tok_line;
        logic [15:0] tok_col;
        logic [15:0] tok_len;
        logic        dot_seen;
        logic [7:0]  held_op;
        logic [47:0] prefix;
        logic [47:0] word_text [9];
        int          word_len [9];
        logic [5:0]  word_kind [9];
        t_out_item   step_tokens [$];
        t_out_item   pending_tokens [$];
        int unsigned errors;
        int unsigned checked;

        function new();
            string names [9];
            names = '{"return", "if", "else", "for", "while", "char", "float", "int", "void"};
            foreach (names[i]) begin
                word_text[i] = '0;
                for (int j = 0; j < names[i].len(); j++) begin
                    word_text[i][8*j +: 8] = names[i][j];
                end
                word_len[i]  = names[i].len();
                word_kind[i] = (i == 0) ? K_RETURN : (i < 5) ? K_KEYWORD : K_TYPE;
            end
            mode     = M_IDLE;
            line_no  = 16'd1;
            col_no   = 16'd1;
            tok_line = '0;
            tok_col  = '0;
            tok_len  = '0;
            dot_seen = 1'b0;
            held_op  = '0;
            prefix   = '0;
            errors   = 0;
            checked  = 0;
        endfunction

        function logic is_letter(input logic [7:0] c);
            return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
        endfunction

        function logic is_numeral(input logic [7:0] c);
            return c >= "0" && c <= "9";
        endfunction

        function logic is_blank(input logic [7:0] c);
            return c == " " || (c >= 8'h09 && c <= 8'h0D);
        endfunction

        function logic [15:0] bump(input logic [15:0] v);
            return (v == 16'hFFFF) ? v : v + 16'd1;
        endfunction

        function logic [5:0] lone_code(input logic [7:0] c);
            case (c)
                "(":     return K_LPAREN;
                ")":     return K_RPAREN;
                "{":     return K_LBRACE;
                "}":     return K_RBRACE;
                "[":     return K_LBRACKET;
                "]":     return K_RBRACKET;
                ";":     return K_SEMI;
                ",":     return K_COMMA;
                "*":     return K_STAR;
                "/":     return K_SLASH;
                "%":     return K_PERCENT;
                default: return K_SYMBOL;
            endcase
        endfunction

        function logic pair_lookup(input logic [7:0] c, output logic [7:0] second,
                                   output logic [5:0] joined, output logic [5:0] lone);
            second = "=";
            joined = K_SYMBOL;
            lone   = K_SYMBOL;
            case (c)
                "+": begin second = "+"; joined = K_INC;  lone = K_PLUS;   end
                "-": begin second = "-"; joined = K_DEC;  lone = K_MINUS;  end
                "!": begin joined = K_NE;  lone = K_NOT;    end
                "&": begin second = "&"; joined = K_LAND; lone = K_AMP;    end
                "=": begin joined = K_EQ;  lone = K_ASSIGN; end
                ">": begin joined = K_GE;  lone = K_GT;     end
                "<": begin joined = K_LE;  lone = K_LT;     end
                "|": begin second = "|"; joined = K_LOR;  lone = K_SYMBOL; end
                default: return 1'b0;
            endcase
            return 1'b1;
        endfunction

        function void push_tok(input logic [5:0] kind, input logic [15:0] ln,
                               input logic [15:0] col, input logic [15:0] len);
            t_out_item t;
            if (step_tokens.size() >= 2) return;
            t.token_kind   = kind;
            t.start_line   = ln;
            t.start_column = col;
            t.token_length = len;
            t.last_of_run  = 1'b0;
            step_tokens.insert(step_tokens.size(), t);
        endfunction

        function void push_open(input logic [5:0] kind);
            push_tok(kind, tok_line, tok_col, tok_len);
        endfunction

        function logic [5:0] word_class();
            for (int i = 0; i < 9; i++) begin
                if (int'(tok_len) == word_len[i] && prefix == word_text[i]) return word_kind[i];
            end
            return K_IDENT;
        endfunction

        function void start_token(input logic [7:0] c);
            logic [7:0] sec;
            logic [5:0] joined;
            logic [5:0] lone;
            tok_line = line_no;
            tok_col  = col_no;
            tok_len  = 16'd1;
            dot_seen = 1'b0;
            prefix   = '0;
            if (is_blank(c)) begin
                mode    = M_IDLE;
                tok_len = '0;
            end else if (is_letter(c) || c == CH_UNDER) begin
                mode        = M_WORD;
                prefix[7:0] = c;
            end else if (is_numeral(c)) begin
                mode = M_NUM;
            end else if (c == CH_DQUOTE) begin
                mode = M_STR;
            end else if (c == CH_SQUOTE) begin
                mode = M_CHR_OPEN;
            end else if (c == CH_HASH) begin
                mode = M_PRE;
            end else if (pair_lookup(c, sec, joined, lone)) begin
                mode    = M_OPER;
                held_op = c;
            end else begin
                mode = M_IDLE;
                push_open(lone_code(c));
            end
        endfunction

        function void flush_open();
            logic [7:0] sec;
            logic [5:0] joined;
            logic [5:0] lone;
            case (mode)
                M_WORD:                       push_open(word_class());
                M_NUM:                        push_open(dot_seen ? K_FLOAT : K_INT);
                M_STR, M_CHR_OPEN, M_CHR_BODY: push_open(K_ERROR);
                M_PRE:                        push_open(K_PRE);
                M_OPER: begin
                    void'(pair_lookup(held_op, sec, joined, lone));
                    push_open(lone);
                end
                default: ;
            endcase
        endfunction

        function void note_byte(input t_in_item r);
            logic [7:0] c;
            logic [7:0] sec;
            logic [5:0] joined;
            logic [5:0] lone;
            logic       restart;
            c       = r.char_code;
            restart = 1'b0;
            step_tokens.delete();
            if (r.end_of_input) begin
                flush_open();
                push_tok(K_END, line_no, col_no, 16'd0);
                mode     = M_IDLE;
                tok_len  = '0;
                dot_seen = 1'b0;
                held_op  = '0;
                prefix   = '0;
            end else begin
                case (mode)
                    M_WORD: begin
                        if (is_letter(c) || is_numeral(c) || c == CH_UNDER) begin
                            if (tok_len < CTOK_KEYWORD_CHARS) prefix[8*tok_len +: 8] = c;
                            tok_len = bump(tok_len);
                        end else begin
                            push_open(word_class());
                            restart = 1'b1;
                        end
                    end
                    M_NUM: begin
                        if (is_numeral(c)) begin
                            tok_len = bump(tok_len);
                        end else if (c == CH_DOT && !dot_seen) begin
                            dot_seen = 1'b1;
                            tok_len  = bump(tok_len);
                        end else if (c == CH_DOT) begin
                            push_open(K_ERROR);
                            restart = 1'b1;
                        end else begin
                            push_open(dot_seen ? K_FLOAT : K_INT);
                            restart = 1'b1;
                        end
                    end
                    M_STR: begin
                        tok_len = bump(tok_len);
                        if (c == CH_DQUOTE) begin
                            push_open(K_STRING);
                            mode = M_IDLE;
                        end
                    end
                    M_CHR_OPEN: begin
                        tok_len = bump(tok_len);
                        if (c == CH_SQUOTE) begin
                            push_open(K_CHAR);
                            mode = M_IDLE;
                        end else begin
                            mode = M_CHR_BODY;
                        end
                    end
                    M_CHR_BODY: begin
                        if (c == CH_SQUOTE) begin
                            tok_len = bump(tok_len);
                            push_open(K_CHAR);
                            mode = M_IDLE;
                        end else begin
                            push_open(K_ERROR);
                            restart = 1'b1;
                        end
                    end
                    M_PRE: begin
                        if (c == CH_NL) begin
                            push_open(K_PRE);
                            restart = 1'b1;
                        end else begin
                            tok_len = bump(tok_len);
                        end
                    end
                    M_OPER: begin
                        if (pair_lookup(held_op, sec, joined, lone) && c == sec) begin
                            tok_len = bump(tok_len);
                            push_open(joined);
                            mode = M_IDLE;
                        end else begin
                            push_open(lone);
                            restart = 1'b1;
                        end
                        held_op = '0;
                    end
                    default: restart = 1'b1;
                endcase
                if (restart) start_token(c);
                if (c == CH_NL) begin
                    line_no = bump(line_no);
                    col_no  = 16'd1;
                end else begin
                    col_no = bump(col_no);
                end
            end
            if (step_tokens.size() > 0) step_tokens[step_tokens.size()-1].last_of_run = 1'b1;
            foreach (step_tokens[i]) pending_tokens.insert(pending_tokens.size(), step_tokens[i]);
        endfunction

        task report(input string what, input int unsigned got_v, input int unsigned want_v);
            errors++;
            if (errors <= 40) begin
                $display("MISMATCH %s: got %0d expected %0d (token %0d)",
                         what, got_v, want_v, checked);
            end
        endtask

        task check_token(input t_out_item got);
            t_out_item want;
            if (pending_tokens.size() == 0) begin
                report("token with none outstanding", got.token_kind, 0);
                return;
            end
            want = pending_tokens[0];
            pending_tokens.delete(0);
            checked++;
            if (got.token_kind != want.token_kind)
                report("token_kind", got.token_kind, want.token_kind);
            if (got.start_line != want.start_line)
                report("start_line", got.start_line, want.start_line);
            if (got.start_column != want.start_column)
                report("start_column", got.start_column, want.start_column);
            if (got.token_length != want.token_length)
                report("token_length", got.token_length, want.token_length);
            if (got.last_of_run != want.last_of_run)
                report("last_of_run", got.last_of_run, want.last_of_run);
        endtask
    endclass

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_item  i_in_req;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_item o_out_req;

    token_scoreboard sb;
    int              send_idle_pct  = 0;
    int              recv_stall_pct = 0;
    int unsigned     bytes_sent     = 0;
    int unsigned     idle_cycles    = 0;

    string word_list [9] = '{"return", "if", "else", "for", "while",
                             "char", "float", "int", "void"};
    string op_list [33] = '{"++", "+", "--", "-", "!=", "!", "&&", "&", "*", "/", "%",
                            "==", "=", ">=", ">", "<=", "<", "||", "|", "(", ")", "{",
                            "}", "[", "]", ";", ",", "@", "$", "~", "?", ":", "."};
    string head_chars = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
    string tail_chars = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
    logic [7:0] blank_chars [6] = '{8'h20, 8'h09, 8'h0A, 8'h0D, 8'h0B, 8'h0C};

    c_subset_tokenizer u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_req   (o_out_req)
    );

    initial i_clk = 1'b0;
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        i_out_ready = ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                sb.note_byte(i_in_req);
                bytes_sent++;
            end
            if (o_out_valid && i_out_ready) sb.check_token(o_out_req);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
    end

    initial begin : watchdog
        while (idle_cycles < WATCHDOG_LIMIT) @(posedge i_clk);
        $display("Run stalled for %0d cycles", WATCHDOG_LIMIT);
        $display("** c_subset_tokenizer: FAILED **");
        $finish;
    end

    task automatic send_byte(input logic [7:0] c, input logic eoi);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid            = 1'b1;
        i_in_req.char_code    = c;
        i_in_req.end_of_input = eoi;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
    endtask

    task automatic send_eoi();
        send_byte(8'($urandom_range(255)), 1'b1);
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (sb.pending_tokens.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic send_random_token();
        int         pick;
        int         n;
        string      s;
        logic [7:0] b;
        pick = $urandom_range(99);
        if (pick < 10) begin
            send_byte(8'($urandom_range(255)), 1'b0);
        end else if (pick < 22) begin
            s = word_list[$urandom_range(8)];
            n = $urandom_range(5);
            if (n == 0) s = {s, "s"};
            else if (n == 1) s = s.substr(0, s.len() - 2);
            send_text(s);
        end else if (pick < 34) begin
            send_byte(head_chars[$urandom_range(head_chars.len() - 1)], 1'b0);
            n = ($urandom_range(4) == 0) ? $urandom_range(11) : $urandom_range(5);
            repeat (n) send_byte(tail_chars[$urandom_range(tail_chars.len() - 1)], 1'b0);
        end else if (pick < 44) begin
            repeat ($urandom_range(4) + 1) send_byte(8'("0" + $urandom_range(9)), 1'b0);
            if ($urandom_range(1)) begin
                send_byte(CH_DOT, 1'b0);
                repeat ($urandom_range(3)) send_byte(8'("0" + $urandom_range(9)), 1'b0);
                if ($urandom_range(4) == 0) begin
                    send_byte(CH_DOT, 1'b0);
                    repeat ($urandom_range(2)) send_byte(8'("0" + $urandom_range(9)), 1'b0);
                end
            end
        end else if (pick < 51) begin
            send_byte(CH_DQUOTE, 1'b0);
            repeat ($urandom_range(8)) begin
                b = 8'($urandom_range(126, 32));
                if (b == CH_DQUOTE) b = "q";
                send_byte(b, 1'b0);
            end
            if ($urandom_range(6) != 0) send_byte(CH_DQUOTE, 1'b0);
        end else if (pick < 58) begin
            send_byte(CH_SQUOTE, 1'b0);
            if ($urandom_range(6) != 0) send_byte(8'($urandom_range(126, 32)), 1'b0);
            if ($urandom_range(6) != 0) send_byte(CH_SQUOTE, 1'b0);
        end else if (pick < 63) begin
            send_byte(CH_HASH, 1'b0);
            repeat ($urandom_range(10)) send_byte(8'($urandom_range(126, 32)), 1'b0);
            if ($urandom_range(9) != 0) send_byte(CH_NL, 1'b0);
        end else if (pick < 85) begin
            send_text(op_list[$urandom_range(32)]);
        end else if (pick < 98) begin
            repeat ($urandom_range(2) + 1) send_byte(blank_chars[$urandom_range(5)], 1'b0);
        end else begin
            send_eoi();
        end
    endtask

    initial begin
        int idle_mix [4];
        int stall_mix [4];
        int unsigned goal;
        idle_mix  = '{0, 78, 0, 37};
        stall_mix = '{0, 0, 78, 37};
        sb         = new();
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_req   = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // opening: preproc line, type, ident, double-dot number, char, lone bar, open string
        send_text("#a\nint _x=3.5.;'q'|\"u");
        send_eoi();
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(CH_SQUOTE, 1'b0);
        send_eoi();

        for (int p = 0; p < 4; p++) begin
            send_idle_pct  = idle_mix[p];
            recv_stall_pct = stall_mix[p];
            goal           = bytes_sent + PHASE_ITEMS;
            while (bytes_sent < goal) send_random_token();
            if (p == 1) drain();
        end

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_text("int a<=b;");
        send_eoi();
        drain();

        if (sb.pending_tokens.size() != 0)
            sb.report("tokens never delivered", sb.pending_tokens.size(), 0);
        $display("Streamed %0d source bytes over four handshake mixes and a drain pause;",
                 bytes_sent);
        $display("%0d tokens compared, %0d mismatches.", sb.checked, sb.errors);
        if (sb.errors == 0) begin
            $display("** c_subset_tokenizer: PASSED **");
        end else begin
            $display("** c_subset_tokenizer: FAILED **");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
hw/rtl/ctok_pkg.sv
hw/rtl/ctok_lexer.sv
hw/rtl/ctok_out_queue.sv
hw/rtl/c_subset_tokenizer.sv
hw/rtl/ctok_checker.sv
dv/c_subset_tokenizer_tb.sv
